// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- hw/rtl/icu_pkg.sv -----
// Shared types and constants of the integer calculation unit
package icu_pkg;

  localparam int unsigned VALUE_W = 63;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_SUB    = 3'd1,
    OP_MUL    = 3'd2,
    OP_DIV    = 3'd3,
    OP_MOD    = 3'd4,
    OP_SQUARE = 3'd5,
    OP_GCD    = 3'd6,
    OP_LCM    = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_GCD,
    ST_LDIV,
    ST_MUL,
    ST_MRES,
    ST_OUT
  } state_e;

endpackage

// ----- hw/rtl/integer_calc_unit_with_gcd_lcm_unit.sv -----
// Top level of the integer calculation unit with gcd and lcm
// One item at a time: in_stall_o stays high from acceptance until the result
// is taken. Add and sub go straight to the output state, mul and square pass
// through the multiply and result states, div and mod through the divider,
// gcd runs one division per Euclid remainder step, and lcm adds one more
// division and a multiply. The shared one-bit-per-cycle divider sets the pace;
// the worst case is lcm of two consecutive Fibonacci numbers, 44 remainder
// steps for 31-bit operands. A zero operand (operand_b ignored for square)
// gives status 1 and value 0.
module integer_calc_unit_with_gcd_lcm_unit import icu_pkg::*; #(
  parameter int unsigned OPERAND_BITS = 31
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [2:0]                req_type_i,
  input  logic [OPERAND_BITS-1:0]   operand_a_i,
  input  logic [OPERAND_BITS-1:0]   operand_b_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [VALUE_W-1:0] value_o,
  output logic                      status_o
);

  localparam int unsigned W = OPERAND_BITS;

  state_e            state_q, state_d;
  op_e               op_q, op_d, op_in;
  logic [W-1:0]      a_q, a_d;
  logic [W-1:0]      b_q, b_d;
  logic [W-1:0]      small_q, small_d;
  logic [VALUE_W-1:0] value_q, value_d;
  logic              status_q, status_d;
  logic              bad;
  logic              a_gt_b;

  logic              div_start, div_done;
  logic [W-1:0]      div_dividend, div_divisor, div_quo, div_rem;
  logic              mul_en;
  logic [W-1:0]      mul_a, mul_b;
  logic [2*W-1:0]    prod;

  assign op_in  = op_e'(req_type_i);
  assign bad    = (op_in == OP_SQUARE) ? (operand_a_i == '0)
                                       : ((operand_a_i == '0) || (operand_b_i == '0));
  assign a_gt_b = operand_a_i > operand_b_i;

  icu_div #(.OPERAND_BITS(OPERAND_BITS)) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  assign mul_en = (state_q == ST_MUL);
  assign mul_a  = (op_q == OP_LCM) ? div_quo : a_q;
  assign mul_b  = (op_q == OP_SQUARE) ? a_q : b_q;

  icu_mul #(.OPERAND_BITS(OPERAND_BITS)) u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (bad) begin
            state_d = ST_OUT;
          end else begin
            case (op_in)
              OP_ADD, OP_SUB:    state_d = ST_OUT;
              OP_MUL, OP_SQUARE: state_d = ST_MUL;
              OP_DIV, OP_MOD:    state_d = ST_DIV;
              default:           state_d = ST_GCD;
            endcase
          end
        end
      end
      ST_DIV: begin
        if (div_done) state_d = ST_OUT;
      end
      ST_GCD: begin
        if (div_done && (div_rem == '0)) begin
          state_d = (op_q == OP_GCD) ? ST_OUT : ST_LDIV;
        end
      end
      ST_LDIV: begin
        if (div_done) state_d = ST_MUL;
      end
      ST_MUL:  state_d = ST_MRES;
      ST_MRES: state_d = ST_OUT;
      ST_OUT: begin
        if (!out_stall_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    op_d         = op_q;
    a_d          = a_q;
    b_d          = b_q;
    small_d      = small_q;
    value_d      = value_q;
    status_d     = status_q;
    div_start    = 1'b0;
    div_dividend = operand_a_i;
    div_divisor  = operand_b_i;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d     = op_in;
          a_d      = operand_a_i;
          b_d      = operand_b_i;
          status_d = bad;
          value_d  = '0;
          if (!bad) begin
            case (op_in)
              OP_ADD: value_d = VALUE_W'(operand_a_i) + VALUE_W'(operand_b_i);
              OP_SUB: value_d = VALUE_W'(operand_a_i) - VALUE_W'(operand_b_i);
              OP_DIV, OP_MOD: div_start = 1'b1;
              OP_GCD, OP_LCM: begin
                div_start    = 1'b1;
                div_dividend = a_gt_b ? operand_a_i : operand_b_i;
                div_divisor  = a_gt_b ? operand_b_i : operand_a_i;
                small_d      = div_divisor;
              end
              default: value_d = '0;
            endcase
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          value_d = (op_q == OP_DIV) ? VALUE_W'(div_quo) : VALUE_W'(div_rem);
        end
      end
      ST_GCD: begin
        if (div_done) begin
          if (div_rem == '0) begin
            value_d = VALUE_W'(small_q);
            if (op_q == OP_LCM) begin
              div_start    = 1'b1;
              div_dividend = a_q;
              div_divisor  = small_q;
            end
          end else begin
            div_start    = 1'b1;
            div_dividend = small_q;
            div_divisor  = div_rem;
            small_d      = div_rem;
          end
        end
      end
      ST_MRES: value_d = VALUE_W'(prod);
      default: value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    a_q      <= a_d;
    b_q      <= b_d;
    small_q  <= small_d;
    value_q  <= value_d;
    status_q <= status_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign value_o     = value_q;
  assign status_o    = status_q;

endmodule

// ----- hw/rtl/icu_div.sv -----
// Iterative restoring divider, one quotient bit per cycle
module icu_div import icu_pkg::*; #(
  parameter int unsigned OPERAND_BITS = 31
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [OPERAND_BITS-1:0] dividend_i,
  input  logic [OPERAND_BITS-1:0] divisor_i,
  output logic                    done_o,
  output logic [OPERAND_BITS-1:0] quotient_o,
  output logic [OPERAND_BITS-1:0] remainder_o
);

  localparam int unsigned W     = OPERAND_BITS;
  localparam int unsigned CNT_W = $clog2(OPERAND_BITS);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [W-1:0]     rem_q, rem_d;
  logic [W-1:0]     quo_q, quo_d;
  logic [W-1:0]     dvs_q, dvs_d;
  logic [W:0]       shifted;
  logic [W+1:0]     diff;
  logic             ge;

  assign shifted = {rem_q, quo_q[W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
  assign ge      = ~diff[W+1];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(W - 1);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[W-1:0] : shifted[W-1:0];
      quo_d = {quo_q[W-2:0], ge};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// ----- hw/rtl/icu_mul.sv -----
// Registered multiplier shared by product, square and lcm
module icu_mul import icu_pkg::*; #(
  parameter int unsigned OPERAND_BITS = 31
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [OPERAND_BITS-1:0]   a_i,
  input  logic [OPERAND_BITS-1:0]   b_i,
  output logic [2*OPERAND_BITS-1:0] prod_o
);

  logic [2*OPERAND_BITS-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= (2*OPERAND_BITS)'(a_i) * (2*OPERAND_BITS)'(b_i);
    end
  end

  assign prod_o = prod_q;

endmodule

// ----- hw/rtl/icu_checker.sv -----
// Port-level checks of the integer calculation unit and their binding
`include "assert_macros.svh"

module icu_checker import icu_pkg::*; #(
  parameter int unsigned OPERAND_BITS = 31
) (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic [2:0]                req_type_i,
  input logic [OPERAND_BITS-1:0]   operand_a_i,
  input logic [OPERAND_BITS-1:0]   operand_b_i,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic signed [VALUE_W-1:0] value_o,
  input logic                      status_o
);

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(value_o) && $stable(status_o))
  `ASSERT_IMPLY(a_err_zero, clk_i, rst_ni, out_valid_o && status_o, value_o == '0)
  `ASSERT_IMPLY(a_one_item, clk_i, rst_ni, !in_stall_o, !out_valid_o)
  `ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

endmodule

bind integer_calc_unit_with_gcd_lcm_unit icu_checker #(.OPERAND_BITS(OPERAND_BITS)) u_icu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .req_type_i  (req_type_i),
  .operand_a_i (operand_a_i),
  .operand_b_i (operand_b_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .value_o     (value_o),
  .status_o    (status_o)
);

// ----- tb/sv/tb_integer_calc_unit_with_gcd_lcm_unit.sv -----
`timescale 1ns / 1ps
// Testbench for the integer calculation unit: directed and random items checked against a predictor
module tb_integer_calc_unit_with_gcd_lcm_unit;
  import icu_pkg::*;

  localparam int unsigned OPW         = 31;
  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int unsigned HOLD_CYCLES = 2500;
  localparam int unsigned RANDOM_ITEMS = 336;

  localparam logic [OPW-1:0] A_MAX = '1;
  localparam logic [OPW-1:0] FIB46 = 31'd1836311903;
  localparam logic [OPW-1:0] FIB45 = 31'd1134903170;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               status;
  } answer_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_TOGGLE,
    RX_HEAVY
  } rx_mode_e;

  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      in_valid_i  = 1'b0;
  logic                      in_stall_o;
  logic [2:0]                req_type_i  = OP_ADD;
  logic [OPW-1:0]            operand_a_i = '0;
  logic [OPW-1:0]            operand_b_i = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic signed [VALUE_W-1:0] value_o;
  logic                      status_o;

  answer_t     answer_q[$];
  int unsigned mismatches = 0;
  int unsigned checked    = 0;
  int unsigned cycle_count = 0;
  int unsigned op_count[8];
  int unsigned zero_count = 0;
  int unsigned burst_left = 0;
  int unsigned hold_asked = 0;
  int unsigned hold_seen  = 0;
  int unsigned hold_left  = 0;
  int unsigned mode_left  = 0;
  rx_mode_e    rx_mode    = RX_OPEN;

  integer_calc_unit_with_gcd_lcm_unit #(
    .OPERAND_BITS(OPW)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .req_type_i (req_type_i),
    .operand_a_i(operand_a_i),
    .operand_b_i(operand_b_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .value_o    (value_o),
    .status_o   (status_o)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  function automatic logic [63:0] common_divisor(input logic [63:0] x, input logic [63:0] y);
    logic [63:0] r;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    return x;
  endfunction

  function automatic answer_t calc_answer(input op_e op, input logic [OPW-1:0] a,
                                          input logic [OPW-1:0] b);
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] res;
    answer_t     ans;
    ans = '0;
    x = 64'(a);
    y = 64'(b);
    if (a == 0 || (op != OP_SQUARE && b == 0)) begin
      ans.status = 1'b1;
      return ans;
    end
    case (op)
      OP_ADD:    res = x + y;
      OP_SUB:    res = x - y;
      OP_MUL:    res = x * y;
      OP_DIV:    res = x / y;
      OP_MOD:    res = x % y;
      OP_SQUARE: res = x * x;
      OP_GCD:    res = common_divisor(x, y);
      default:   res = (x / common_divisor(x, y)) * y;
    endcase
    ans.value = res[VALUE_W-1:0];
    return ans;
  endfunction

  function automatic logic [OPW-1:0] pick_operand();
    int unsigned kind;
    kind = $urandom_range(0, 99);
    if (kind < 6) return '0;
    if (kind < 38) return OPW'($urandom_range(1, 255));
    if (kind < 46) return A_MAX - OPW'($urandom_range(0, 3));
    if (kind < 52) return OPW'(1) << $urandom_range(0, OPW-1);
    return OPW'($urandom());
  endfunction

  task automatic send_item(input op_e op, input logic [OPW-1:0] a, input logic [OPW-1:0] b);
    int unsigned gap;
    answer_t     ans;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    req_type_i  <= op;
    operand_a_i <= a;
    operand_b_i <= b;
    in_valid_i  <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    ans = calc_answer(op, a, b);
    answer_q.push_back(ans);
    op_count[op]++;
    if (ans.status) zero_count++;
  endtask

  task automatic wait_all_answered();
    in_valid_i <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (answer_q.size() != 0);
  endtask

  task automatic test_edge_values();
    send_item(OP_ADD, A_MAX, A_MAX);
    send_item(OP_ADD, 1, 1);
    send_item(OP_SUB, 1, A_MAX);
    send_item(OP_SUB, A_MAX, 1);
    send_item(OP_SUB, 9, 9);
    send_item(OP_MUL, A_MAX, A_MAX);
    send_item(OP_DIV, A_MAX, 1);
    send_item(OP_DIV, 7, A_MAX);
    send_item(OP_MOD, 5, A_MAX);
    send_item(OP_MOD, A_MAX, 2);
    send_item(OP_SQUARE, A_MAX, 0);
    send_item(OP_GCD, FIB46, FIB45);
    send_item(OP_LCM, FIB46, FIB45);
    send_item(OP_LCM, A_MAX, A_MAX - 1);
    send_item(OP_GCD, 12, 12);
    send_item(OP_GCD, 1, A_MAX);
  endtask

  task automatic test_zero_operands();
    send_item(OP_SQUARE, 0, 5);
    send_item(OP_ADD, 0, 5);
    send_item(OP_MUL, 5, 0);
    send_item(OP_DIV, A_MAX, 0);
    send_item(OP_LCM, 0, 0);
    send_item(OP_GCD, 0, A_MAX);
  endtask

  task automatic test_long_hold();
    hold_asked++;
    send_item(OP_ADD, 3, 4);
    send_item(OP_SUB, 4, 3);
    send_item(OP_MUL, 300, 7);
    send_item(OP_SQUARE, 11, A_MAX);
    send_item(OP_MOD, 100, 7);
    send_item(OP_DIV, 100, 7);
  endtask

  task automatic test_quiet_drain();
    send_item(OP_GCD, 1071, 462);
    send_item(OP_LCM, 21, 6);
    send_item(OP_SUB, 2, 7);
    wait_all_answered();
    send_item(OP_LCM, 4, 6);
    send_item(OP_GCD, 48, 180);
    send_item(OP_ADD, 1, A_MAX);
    wait_all_answered();
    send_item(OP_MUL, 65536, 32768);
    send_item(OP_DIV, 1, 1);
  endtask

  task automatic test_random_mix(input int unsigned n);
    op_e            op;
    logic [OPW-1:0] a;
    logic [OPW-1:0] b;
    int unsigned    k;
    for (int unsigned i = 0; i < n; i++) begin
      op = op_e'($urandom_range(0, 7));
      if ((op == OP_GCD || op == OP_LCM) && $urandom_range(0, 1) == 1) begin
        k = $urandom_range(1, 65535);
        a = OPW'(k * $urandom_range(1, 30000));
        b = OPW'(k * $urandom_range(1, 30000));
      end else begin
        a = pick_operand();
        b = pick_operand();
      end
      send_item(op, a, b);
    end
  endtask

  always @(posedge clk_i) begin
    if (hold_seen != hold_asked) begin
      hold_seen = hold_asked;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 200);
      end
      mode_left--;
      case (rx_mode)
        RX_OPEN:   out_stall_i <= 1'b0;
        RX_COIN:   out_stall_i <= $urandom_range(0, 1);
        RX_TOGGLE: out_stall_i <= ~out_stall_i;
        default:   out_stall_i <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk_i) begin : check_results
    answer_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (answer_q.size() == 0) begin
        $error("unexpected result: value %0d status %0b", value_o, status_o);
        mismatches++;
      end else begin
        want = answer_q.pop_front();
        checked++;
        if (value_o !== want.value) begin
          $error("value: expected %0d, actual %0d", $signed(want.value), value_o);
          mismatches++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0b, actual %0b", want.status, status_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d results outstanding", cycle_count,
             answer_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_edge_values();
    test_zero_operands();
    test_long_hold();
    test_quiet_drain();
    test_random_mix(RANDOM_ITEMS);
    wait_all_answered();
    repeat (40) @(posedge clk_i);
    if (answer_q.size() != 0) begin
      $error("%0d results never arrived", answer_q.size());
      mismatches++;
    end
    $display("covered add %0d, sub %0d, mul %0d, div %0d, mod %0d, square %0d, gcd %0d, lcm %0d",
             op_count[OP_ADD], op_count[OP_SUB], op_count[OP_MUL], op_count[OP_DIV],
             op_count[OP_MOD], op_count[OP_SQUARE], op_count[OP_GCD], op_count[OP_LCM]);
    $display("%0d results checked, %0d with a zero operand, %0d mismatches, %0d cycles",
             checked, zero_count, mismatches, cycle_count);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
